// ----- hw/rtl/hvt_pkg.sv -----
// Package: shared constants and types for the histogram valley threshold core
package hvt_pkg;

    localparam int BIN_COUNT_DEF  = 256;
    localparam int COUNT_BITS_DEF = 20;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [1:0] REG_AVERAGE_WINDOW  = 2'd0;
    localparam logic [1:0] REG_LOCAL_WIDTH     = 2'd1;
    localparam logic [1:0] REG_LOBE_AREA_LIMIT = 2'd2;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       last_pixel;
    } hvt_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SMOOTH,
        ST_MARK,
        ST_MARK_CHK,
        ST_SPAN,
        ST_SPAN_RD,
        ST_DONE,
        ST_CLEAR
    } hvt_state_t;

endpackage

// ----- hw/rtl/histogram_valley_threshold_core.sv -----
// Top level: histogram valley threshold core
//  channel  | handshake        | words
//  pixel    | start / busy     | pixel_value, last_pixel
//  result   | done strobe      | threshold_bin, found
//  config   | cfg_we           | cfg_index, cfg_data
// A pixel passes through the queue; the back end reads and then writes each pixel's count before taking the next.
// After the last pixel the back end writes its count, smooths each bin, tests each bin for a minimum,
// walks the span bins, reports the result and clears the histogram.
// busy is high from the last pixel to the result strobe, and while the queue is full.
// Reset starts a clearing pass; pixels queue up behind it.
// The receiver cannot stall the done strobe.
module histogram_valley_threshold_core #(
    parameter int BIN_COUNT  = hvt_pkg::BIN_COUNT_DEF,
    parameter int COUNT_BITS = hvt_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  pixel_value,
    input  logic        last_pixel,
    output logic        done,
    output logic [7:0]  threshold_bin,
    output logic        found,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    hvt_pkg::hvt_word_t push_word, head_word;
    logic push, pop, q_empty, q_full;
    logic [4:0]  average_window;
    logic [5:0]  local_width;
    logic [19:0] lobe_area_limit;

    hvt_front u_front (
        .clk, .rst_n, .start, .pixel_value, .last_pixel, .q_full,
        .analysing(!done),
        .busy, .push, .push_word, .cfg_we, .cfg_index, .cfg_data,
        .average_window, .local_width, .lobe_area_limit
    );

    hvt_queue u_queue (
        .clk, .rst_n, .push, .push_word, .pop, .empty(q_empty), .full(q_full),
        .head_word
    );

    hvt_back #(.BIN_COUNT(BIN_COUNT), .COUNT_BITS(COUNT_BITS)) u_back (
        .clk, .rst_n, .q_empty, .q_word(head_word), .q_pop(pop),
        .average_window, .local_width, .lobe_area_limit,
        .done, .threshold_bin, .found
    );
endmodule

// ----- hw/rtl/hvt_queue.sv -----
// Queue: short first-in first-out buffer between the pixel front and the analysis back
module hvt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hvt_pkg::hvt_word_t push_word,
    input  logic              pop,
    output logic              empty,
    output logic              full,
    output hvt_pkg::hvt_word_t head_word
);
    localparam int D = hvt_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(D);

    hvt_pkg::hvt_word_t mem_reg [D];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   fill_reg;

    assign empty     = (fill_reg == '0);
    assign full      = (fill_reg == (AW+1)'(D));
    assign head_word = mem_reg[rd_ptr_reg];

    // store pushed words
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    // advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end
endmodule

// ----- hw/rtl/hvt_back.sv -----
// Back end: histogram counting, smoothing, minimum marking and span search
module hvt_back #(
    parameter int BIN_COUNT  = hvt_pkg::BIN_COUNT_DEF,
    parameter int COUNT_BITS = hvt_pkg::COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  hvt_pkg::hvt_word_t q_word,
    output logic              q_pop,
    input  logic [4:0]        average_window,
    input  logic [5:0]        local_width,
    input  logic [19:0]       lobe_area_limit,
    output logic              done,
    output logic [7:0]        threshold_bin,
    output logic              found
);
    localparam int BW = $clog2(BIN_COUNT);
    localparam int IW = BW + 1;
    localparam int SW = COUNT_BITS + BW + 1;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    // histogram, smoothed-value and minimum-mark memories
    logic [COUNT_BITS-1:0] hist_mem [BIN_COUNT];
    logic [COUNT_BITS-1:0] smooth_mem [BIN_COUNT];
    logic                  mark_mem [BIN_COUNT];

    hvt_pkg::hvt_state_t state_reg, state_next;
    logic [IW-1:0] i_reg, i_next, k_reg, k_next, j_reg, j_next;
    logic [IW-1:0] prev_reg, prev_next, start_reg, start_next;
    logic [SW-1:0] acc_reg, acc_next, lobe_acc_reg, lobe_acc_next;
    logic          is_min_reg, is_min_next;
    logic [IW-1:0] marks_reg, marks_next, seen_reg, seen_next;
    logic [8:0]    lobes_reg, lobes_next;
    logic          have_prev_reg, have_prev_next;
    logic          pend_reg, pend_next;
    logic [BW-1:0] pend_addr_reg, pend_addr_next;
    logic [7:0]    out_bin_reg, out_bin_next;
    logic          out_found_reg, out_found_next, done_reg, done_next;

    // divider state for floored average
    logic [SW-1:0] div_rem_reg, div_rem_next;
    logic [COUNT_BITS-1:0] div_q_reg, div_q_next;
    logic [5:0]    div_n_reg, div_n_next;
    logic          div_run_reg, div_run_next;

    logic [4:0]    w_eff;
    logic signed [IW+1:0] m_s;
    logic [IW-1:0] m_len;
    logic          m_ok;
    logic [COUNT_BITS-1:0] hist_rd_reg, hcnt_rd_reg, sm_i_reg, sm_k_reg;
    logic          mark_rd_reg;
    logic [BW-1:0] hist_raddr, sm_kaddr, mark_addr;
    logic          wr_hist, wr_smooth, wr_mark, clr_hist;
    logic [BW-1:0] wr_addr;
    logic [COUNT_BITS-1:0] wr_val;
    logic signed [IW+1:0] lo_s, hi_s;
    logic [IW-1:0] lo_v, hi_v;

    assign w_eff = (average_window == 5'd0) ? 5'd1 : average_window;
    assign m_s   = (IW+2)'(BIN_COUNT) - (IW+2)'(w_eff) - (IW+2)'(1);
    assign m_ok  = (m_s > 0);
    assign m_len = m_ok ? m_s[IW-1:0] : '0;

    // clipped neighbourhood bounds for bin i
    always_comb
    begin
        lo_s = $signed({2'b00, i_reg}) - $signed((IW+2)'(local_width));
        hi_s = $signed({2'b00, i_reg}) + $signed((IW+2)'(local_width));
        lo_v = (lo_s < 0) ? '0 : lo_s[IW-1:0];
        hi_v = (hi_s > $signed({2'b00, m_len})) ? m_len : hi_s[IW-1:0];
    end

    // memory ports, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_hist)
            hist_mem[wr_addr] <= wr_val;
        else if (clr_hist)
            hist_mem[k_reg[BW-1:0]] <= '0;
        hist_rd_reg <= hist_mem[hist_raddr];
        if (wr_smooth)
            smooth_mem[i_reg[BW-1:0]] <= div_q_reg;
        sm_k_reg <= smooth_mem[sm_kaddr];
        if (wr_mark)
            mark_mem[i_reg[BW-1:0]] <= is_min_next;
        mark_rd_reg <= mark_mem[mark_addr];
    end

    assign hcnt_rd_reg = hist_rd_reg;

    // hold the smoothed value of bin i for the minimum test
    always_ff @(posedge clk)
    begin
        if (state_reg == hvt_pkg::ST_MARK_CHK && !j_reg[1])
            sm_i_reg <= sm_k_reg;
    end

    // clear the histogram after reset before taking any word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hvt_pkg::ST_CLEAR;
            i_reg         <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            prev_reg      <= '0;
            start_reg     <= '0;
            acc_reg       <= '0;
            lobe_acc_reg  <= '0;
            is_min_reg    <= 1'b0;
            marks_reg     <= '0;
            seen_reg      <= '0;
            lobes_reg     <= '0;
            have_prev_reg <= 1'b0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            out_bin_reg   <= '0;
            out_found_reg <= 1'b0;
            done_reg      <= 1'b0;
            div_rem_reg   <= '0;
            div_q_reg     <= '0;
            div_n_reg     <= '0;
            div_run_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            prev_reg      <= prev_next;
            start_reg     <= start_next;
            acc_reg       <= acc_next;
            lobe_acc_reg  <= lobe_acc_next;
            is_min_reg    <= is_min_next;
            marks_reg     <= marks_next;
            seen_reg      <= seen_next;
            lobes_reg     <= lobes_next;
            have_prev_reg <= have_prev_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            out_bin_reg   <= out_bin_next;
            out_found_reg <= out_found_next;
            done_reg      <= done_next;
            div_rem_reg   <= div_rem_next;
            div_q_reg     <= div_q_next;
            div_n_reg     <= div_n_next;
            div_run_reg   <= div_run_next;
        end
    end

    assign done          = done_reg;
    assign threshold_bin = out_bin_reg;
    assign found         = out_found_reg;

    // sequencer: count pixels, then run the analysis steps one bin at a time
    always_comb
    begin
        logic [SW-1:0] trial;
        logic          cnt_ok;
        state_next     = state_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        prev_next      = prev_reg;
        start_next     = start_reg;
        acc_next       = acc_reg;
        lobe_acc_next  = lobe_acc_reg;
        is_min_next    = is_min_reg;
        marks_next     = marks_reg;
        seen_next      = seen_reg;
        lobes_next     = lobes_reg;
        have_prev_next = have_prev_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        out_bin_next   = out_bin_reg;
        out_found_next = out_found_reg;
        done_next      = 1'b0;
        div_rem_next   = div_rem_reg;
        div_q_next     = div_q_reg;
        div_n_next     = div_n_reg;
        div_run_next   = div_run_reg;
        q_pop          = 1'b0;
        wr_hist        = 1'b0;
        wr_smooth      = 1'b0;
        wr_mark        = 1'b0;
        clr_hist       = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_val         = (hcnt_rd_reg == CMAX) ? hcnt_rd_reg : hcnt_rd_reg + 1'b1;
        hist_raddr     = q_word.pixel_value[BW-1:0];
        sm_kaddr       = k_reg[BW-1:0];
        mark_addr      = k_reg[BW-1:0];
        trial          = '0;
        cnt_ok         = 1'b0;

        case (state_reg)
            hvt_pkg::ST_IDLE:
            begin
                // finish pending increment, then take the next word
                if (pend_reg)
                    wr_hist = 1'b1;
                if (!q_empty && !pend_reg)
                begin
                    q_pop  = 1'b1;
                    cnt_ok = ({1'b0, q_word.pixel_value} < 9'(BIN_COUNT));
                    if (cnt_ok)
                    begin
                        pend_next      = 1'b1;
                        pend_addr_next = q_word.pixel_value[BW-1:0];
                    end
                    if (q_word.last_pixel)
                    begin
                        state_next = hvt_pkg::ST_SMOOTH;
                        i_next = '0;
                        k_next = '0;
                        acc_next = '0;
                        lobes_next = '0;
                        start_next = '0;
                        marks_next = '0;
                        div_run_next = 1'b0;
                        if (cnt_ok)
                            j_next = {1'b1, {(IW-1){1'b0}}};
                        else
                            j_next = '0;
                    end
                end
            end
            hvt_pkg::ST_SMOOTH:
            begin
                // j marks a pending increment to write first
                if (j_reg[IW-1])
                begin
                    wr_hist = 1'b1;
                    j_next  = '0;
                end
                else if (!m_ok)
                begin
                    state_next = hvt_pkg::ST_DONE;
                end
                else if (div_run_reg)
                begin
                    // restoring division, one bit a cycle
                    trial = div_rem_reg - (SW'(w_eff) << div_n_reg);
                    if (!trial[SW-1] && div_rem_reg >= (SW'(w_eff) << div_n_reg))
                    begin
                        div_rem_next = div_rem_reg - (SW'(w_eff) << div_n_reg);
                        div_q_next   = div_q_reg | (COUNT_BITS'(1) << div_n_reg);
                    end
                    if (div_n_reg == 6'd0)
                    begin
                        div_run_next = 1'b0;
                        state_next   = hvt_pkg::ST_SMOOTH;
                        j_next       = {1'b0, 1'b1, {(IW-2){1'b0}}};
                    end
                    else
                        div_n_next = div_n_reg - 1'b1;
                end
                else if (j_reg[IW-2])
                begin
                    // store quotient and step to the next bin
                    wr_smooth = 1'b1;
                    j_next    = '0;
                    acc_next  = '0;
                    k_next    = '0;
                    if (i_reg + 1'b1 == m_len)
                    begin
                        state_next = hvt_pkg::ST_MARK;
                        i_next = '0;
                        k_next = lo_v;
                    end
                    else
                        i_next = i_reg + 1'b1;
                end
                else
                begin
                    // sum W bins: read address issued, data next cycle
                    hist_raddr = BW'(i_reg + k_reg);
                    if (j_reg[0])
                        acc_next = acc_reg + SW'(hcnt_rd_reg);
                    if (k_reg == IW'(w_eff))
                    begin
                        div_rem_next = acc_reg + (j_reg[0] ? SW'(hcnt_rd_reg) : '0);
                        div_q_next   = '0;
                        div_n_next   = 6'(COUNT_BITS - 1);
                        div_run_next = 1'b1;
                        j_next       = '0;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                        j_next = IW'(1);
                    end
                end
            end
            hvt_pkg::ST_MARK:
            begin
                // fetch s[i] first, then scan the window
                sm_kaddr    = i_reg[BW-1:0];
                state_next  = hvt_pkg::ST_MARK_CHK;
                is_min_next = 1'b1;
                k_next      = lo_v;
                j_next      = '0;
            end
            hvt_pkg::ST_MARK_CHK:
            begin
                sm_kaddr = k_reg[BW-1:0];
                if (j_reg[0] && j_reg[1] && sm_k_reg < sm_i_reg)
                    is_min_next = 1'b0;
                if (!j_reg[1])
                    j_next = {j_reg[IW-1:2], 1'b1, j_reg[0]};
                if (k_reg >= hi_v)
                begin
                    if (!(j_reg[0] && j_reg[1]) && lo_v < hi_v)
                        j_next = IW'(3);
                    else
                    begin
                        wr_mark = 1'b1;
                        if (is_min_next)
                            marks_next = marks_reg + 1'b1;
                        state_next = hvt_pkg::ST_IDLE;
                        if (i_reg + 1'b1 == m_len)
                        begin
                            state_next = hvt_pkg::ST_SPAN;
                            i_next = '0;
                            k_next = '0;
                            seen_next = '0;
                            have_prev_next = 1'b0;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                            state_next = hvt_pkg::ST_MARK;
                        end
                    end
                end
                else
                begin
                    if (j_reg[1])
                    begin
                        k_next = k_reg + 1'b1;
                        j_next = IW'(3);
                    end
                end
            end
            hvt_pkg::ST_SPAN:
            begin
                // issue reads of mark and value at k
                mark_addr  = k_reg[BW-1:0];
                sm_kaddr   = k_reg[BW-1:0];
                state_next = hvt_pkg::ST_SPAN_RD;
            end
            hvt_pkg::ST_SPAN_RD:
            begin
                state_next = hvt_pkg::ST_SPAN;
                if (mark_rd_reg)
                begin
                    if (have_prev_reg && seen_reg + 2'd2 <= marks_reg)
                    begin
                        if (SW'(lobe_area_limit) < lobe_acc_reg)
                        begin
                            if (lobes_reg == '0)
                                start_next = prev_reg;
                            lobes_next = lobes_reg + 1'b1;
                        end
                    end
                    have_prev_next = 1'b1;
                    prev_next      = k_reg;
                    seen_next      = seen_reg + 1'b1;
                    lobe_acc_next  = SW'(sm_k_reg);
                end
                else
                    lobe_acc_next = lobe_acc_reg + SW'(sm_k_reg);
                if (k_reg + 1'b1 == m_len)
                    state_next = hvt_pkg::ST_DONE;
                else
                    k_next = k_reg + 1'b1;
            end
            hvt_pkg::ST_DONE:
            begin
                // report, then clear the histogram
                done_next      = 1'b1;
                out_found_next = m_ok && (lobes_reg > 9'd1);
                out_bin_next   = (m_ok && lobes_reg > 9'd1) ? 8'(start_reg) : 8'd0;
                state_next     = hvt_pkg::ST_CLEAR;
                k_next         = '0;
            end
            hvt_pkg::ST_CLEAR:
            begin
                clr_hist = 1'b1;
                if (k_reg == IW'(BIN_COUNT - 1))
                    state_next = hvt_pkg::ST_IDLE;
                else
                    k_next = k_reg + 1'b1;
            end
            default:
            begin
                state_next = hvt_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

// ----- hw/rtl/hvt_front.sv -----
// Front end: accepts pixel words and the configuration writes
module hvt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [7:0]        pixel_value,
    input  logic              last_pixel,
    input  logic              q_full,
    input  logic              analysing,
    output logic              busy,
    output logic              push,
    output hvt_pkg::hvt_word_t push_word,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [19:0]       cfg_data,
    output logic [4:0]        average_window,
    output logic [5:0]        local_width,
    output logic [19:0]       lobe_area_limit
);
    logic [4:0]  aw_reg;
    logic [5:0]  lw_reg;
    logic [19:0] area_reg;
    logic        hold_reg, hold_next;

    // stall intake while the queue is full, and after a last pixel until the pass ends
    assign busy = q_full || hold_reg;
    assign push = start && !busy;
    assign push_word.pixel_value = pixel_value;
    assign push_word.last_pixel  = last_pixel;
    assign hold_next = (push && last_pixel) ? 1'b1 : (hold_reg && analysing);

    assign average_window  = aw_reg;
    assign local_width     = lw_reg;
    assign lobe_area_limit = area_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg   <= 5'd4;
            lw_reg   <= 6'd5;
            area_reg <= 20'd10;
            hold_reg <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    hvt_pkg::REG_AVERAGE_WINDOW:  aw_reg   <= cfg_data[4:0];
                    hvt_pkg::REG_LOCAL_WIDTH:     lw_reg   <= cfg_data[5:0];
                    hvt_pkg::REG_LOBE_AREA_LIMIT: area_reg <= cfg_data;
                    default:                      area_reg <= area_reg;
                endcase
            end
        end
    end
endmodule
